@@ hdl/lbcs_pkg.sv @@
// ============================================================================
// lbcs_pkg
// Shared types and constants of the LED blink-code sequencer.
// ============================================================================
package lbcs_pkg;

    // Table depth and register defaults
    localparam int unsigned SLOTS_DEF = 10;
    localparam logic [7:0] ON_TICKS_RST   = 8'd2;
    localparam logic [7:0] OFF_FAST_RST   = 8'd6;
    localparam logic [7:0] OFF_SLOW_RST   = 8'd9;
    localparam logic [7:0] GAP_TICKS_RST  = 8'd25;

    // Pure red color mask
    localparam logic [2:0] RGB_RED = 3'b001;

    // Request types
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_BLINK  = 2'd1;
    localparam logic [1:0] REQ_CHANGE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ON_TICKS  = 2'd0;
    localparam logic [1:0] CFG_OFF_FAST  = 2'd1;
    localparam logic [1:0] CFG_OFF_SLOW  = 2'd2;
    localparam logic [1:0] CFG_GAP_TICKS = 2'd3;

    // One slot of the code table
    typedef struct packed {
        logic [2:0] rgb;
        logic [7:0] total;
        logic [7:0] done_cnt;
        logic [7:0] tmr;
        logic [7:0] period;
    } slot_t;

    // Shared compare unit operations
    typedef enum logic {
        ALU_EQ,
        ALU_LT
    } alu_op_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD,
        ST_CLR,
        ST_INC,
        ST_ON,
        ST_PER,
        ST_CNT,
        ST_RST,
        ST_GAP,
        ST_FREE,
        ST_CHG,
        ST_DONE
    } state_t;

endpackage

@@ hdl/lbcs_in_if.sv @@
// ============================================================================
// lbcs_in_if
// Request channel: valid/ready handshake with the request fields.
// ============================================================================
interface lbcs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [3:0] slot_sel;
    logic [2:0] led_color;
    logic [7:0] blink_count;

    modport source (output valid, req_type, slot_sel, led_color, blink_count,
                    input ready);
    modport sink (input valid, req_type, slot_sel, led_color, blink_count,
                  output ready);
endinterface

@@ hdl/lbcs_out_if.sv @@
// ============================================================================
// lbcs_out_if
// Result channel: valid/ready handshake with the result fields.
// ============================================================================
interface lbcs_out_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [3:0] slot_index;
    logic       led_red;
    logic       led_green;
    logic       led_blue;
    logic       busy_res;

    modport source (output valid, accepted, slot_index, led_red, led_green,
                    led_blue, busy_res, input ready);
    modport sink (input valid, accepted, slot_index, led_red, led_green,
                  led_blue, busy_res, output ready);
endinterface

@@ hdl/led_blink_code_sequencer.sv @@
// ============================================================================
// led_blink_code_sequencer
// RGB status-LED blink-code sequencer with a round-robin table of slots.
// ============================================================================
// Usage:
//   Requests arrive on in_ch (valid/ready). A request is a tick, a blink
//   request that takes the lowest free slot, or a change of an occupied
//   slot. Each request gives exactly one result on out_ch: the accepted
//   flag, the slot index, the three LED levels and whether any slot is
//   occupied. Registers are written through cfg_we/cfg_idx/cfg_data;
//   the user must do so only while idle; the block does not enforce it.
// Timing:
//   A request is taken only in the idle state. The next request can be
//   taken in the cycle after the result is loaded. A tick walks the table
//   one slot per cycle, over up to SLOTS slots. It then loads the slot
//   (ST_LOAD), updates it through the shared compare/increment unit
//   (ST_CLR, ST_INC, ST_ON, ST_PER, ST_CNT, ST_RST) and writes it back
//   (ST_GAP). A blink request scans for the lowest free slot. A change
//   writes its slot in ST_CHG; a rejected blink or an unknown request
//   type goes straight to the completion state.
// Reset:
//   All slots free, scan pointer 0, LEDs dark, registers at defaults.
// Stall:
//   The result sits in an output register. A new request is taken while it
//   waits, and its own result is held back until the register is free.
// ============================================================================
module led_blink_code_sequencer
    import lbcs_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    lbcs_in_if.sink    in_ch,
    lbcs_out_if.source out_ch,
    input  logic       cfg_we,
    input  logic [1:0] cfg_idx,
    input  logic [7:0] cfg_data
);

    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Control and datapath registers
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] p_reg, p_next;
    logic [IDX_W-1:0] ct_reg, ct_next;
    logic [IDX_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [2:0]       lit_reg, lit_next;
    logic             hit_reg, hit_next;
    logic             acc_reg, acc_next;
    logic             sel_ok_reg, sel_ok_next;
    logic [1:0]       req_reg, req_next;
    logic [2:0]       color_reg, color_next;
    logic [7:0]       count_reg, count_next;
    slot_t            wk_reg, wk_next;

    logic [7:0] on_reg, fast_reg, slow_reg, gap_reg;

    logic       out_valid_reg, out_valid_next;
    logic       out_acc_reg, out_acc_next;
    logic [3:0] out_idx_reg, out_idx_next;
    logic [2:0] out_lit_reg, out_lit_next;
    logic       out_busy_reg, out_busy_next;

    // Table and shared unit hookups
    slot_t            rd_slot;
    slot_t            wr_slot;
    logic             wr_en;
    logic [SLOTS-1:0] occ;
    alu_op_t          alu_op;
    logic [7:0]       alu_a, alu_b, alu_inc;
    logic             alu_flag;

    logic [IDX_W-1:0] p_succ;
    logic             out_free;

    lbcs_slot_table #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (p_reg),
        .rd_slot (rd_slot),
        .wr_en   (wr_en),
        .wr_idx  (p_reg),
        .wr_slot (wr_slot),
        .occ     (occ)
    );

    lbcs_alu u_alu (
        .op   (alu_op),
        .a    (alu_a),
        .b    (alu_b),
        .flag (alu_flag),
        .inc  (alu_inc)
    );

    // Round-robin successor of the current slot
    assign p_succ   = (p_reg == IDX_W'(SLOTS - 1)) ? '0 : p_reg + 1'b1;
    assign out_free = !out_valid_reg || out_ch.ready;

    assign in_ch.ready = (state_reg == ST_IDLE);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg   <= ON_TICKS_RST;
            fast_reg <= OFF_FAST_RST;
            slow_reg <= OFF_SLOW_RST;
            gap_reg  <= GAP_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_ON_TICKS:  on_reg   <= cfg_data;
                CFG_OFF_FAST:  fast_reg <= cfg_data;
                CFG_OFF_SLOW:  slow_reg <= cfg_data;
                CFG_GAP_TICKS: gap_reg  <= cfg_data;
                default:       on_reg   <= on_reg;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    case (in_ch.req_type)
                        REQ_TICK:   state_next = ST_SCAN;
                        REQ_BLINK:
                        begin
                            if (in_ch.blink_count != 8'd0 && in_ch.led_color != 3'd0)
                                state_next = ST_FREE;
                            else
                                state_next = ST_DONE;
                        end
                        REQ_CHANGE: state_next = ST_CHG;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (occ[p_reg])
                    state_next = ST_LOAD;
                else if (ct_reg == IDX_W'(SLOTS - 1))
                    state_next = ST_DONE;
            end
            ST_LOAD: state_next = ST_CLR;
            ST_CLR:  state_next = ST_INC;
            ST_INC:  state_next = ST_ON;
            ST_ON:   state_next = ST_PER;
            ST_PER:  state_next = ST_CNT;
            ST_CNT:  state_next = ST_RST;
            ST_RST:  state_next = ST_GAP;
            ST_GAP:  state_next = ST_DONE;
            ST_FREE:
            begin
                if (!occ[p_reg] || p_reg == IDX_W'(SLOTS - 1))
                    state_next = ST_DONE;
            end
            ST_CHG:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, table write and shared unit operands per state
    always_comb
    begin
        p_next        = p_reg;
        ct_next       = ct_reg;
        scan_ptr_next = scan_ptr_reg;
        lit_next      = lit_reg;
        hit_next      = hit_reg;
        acc_next      = acc_reg;
        sel_ok_next   = sel_ok_reg;
        req_next      = req_reg;
        color_next    = color_reg;
        count_next    = count_reg;
        wk_next       = wk_reg;
        wr_en         = 1'b0;
        wr_slot       = wk_reg;
        alu_op        = ALU_EQ;
        alu_a         = wk_reg.tmr;
        alu_b         = 8'd0;

        out_valid_next = out_valid_reg && !out_ch.ready;
        out_acc_next   = out_acc_reg;
        out_idx_next   = out_idx_reg;
        out_lit_next   = out_lit_reg;
        out_busy_next  = out_busy_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    req_next    = in_ch.req_type;
                    color_next  = in_ch.led_color;
                    count_next  = in_ch.blink_count;
                    acc_next    = 1'b0;
                    ct_next     = '0;
                    sel_ok_next = ({1'b0, in_ch.slot_sel} < 5'(SLOTS));
                    case (in_ch.req_type)
                        REQ_TICK:   p_next = scan_ptr_reg;
                        REQ_CHANGE: p_next = in_ch.slot_sel[IDX_W-1:0];
                        default:    p_next = '0;
                    endcase
                end
            end
            // Walk to the next occupied slot
            ST_SCAN:
            begin
                if (occ[p_reg])
                    scan_ptr_next = p_reg;
                else if (ct_reg != IDX_W'(SLOTS - 1))
                begin
                    p_next  = p_succ;
                    ct_next = ct_reg + 1'b1;
                end
            end
            ST_LOAD: wk_next = rd_slot;
            // Restart the count once the code has played out
            ST_CLR:
            begin
                alu_op = ALU_LT;
                alu_a  = wk_reg.done_cnt;
                alu_b  = wk_reg.total;
                if (!alu_flag)
                    wk_next.done_cnt = 8'd0;
            end
            // Light at timer zero, then advance the timer
            ST_INC:
            begin
                alu_a = wk_reg.tmr;
                if (wk_reg.tmr == 8'd0)
                    lit_next = wk_reg.rgb;
                wk_next.tmr = alu_inc;
            end
            ST_ON:
            begin
                alu_b = on_reg;
                if (alu_flag)
                    lit_next = 3'd0;
            end
            ST_PER:
            begin
                alu_b    = wk_reg.period;
                hit_next = alu_flag;
            end
            ST_CNT:
            begin
                alu_a = wk_reg.done_cnt;
                if (hit_reg)
                    wk_next.done_cnt = alu_inc;
            end
            ST_RST:
            begin
                alu_op = ALU_LT;
                alu_a  = wk_reg.done_cnt;
                alu_b  = wk_reg.total;
                if (hit_reg && alu_flag)
                    wk_next.tmr = 8'd0;
            end
            // End of session: rewind timer and move on; write slot back
            ST_GAP:
            begin
                alu_b = gap_reg;
                wr_en = 1'b1;
                if (alu_flag)
                begin
                    wr_slot.tmr   = 8'd0;
                    scan_ptr_next = p_succ;
                end
            end
            // Lowest free slot for a blink request
            ST_FREE:
            begin
                if (!occ[p_reg])
                begin
                    wr_en    = 1'b1;
                    wr_slot  = '{rgb: color_reg, total: count_reg, done_cnt: 8'd0,
                                 tmr: 8'd0,
                                 period: (color_reg == RGB_RED) ? slow_reg : fast_reg};
                    acc_next = 1'b1;
                end
                else if (p_reg != IDX_W'(SLOTS - 1))
                    p_next = p_succ;
            end
            // Rewrite an occupied slot, period kept
            ST_CHG:
            begin
                if (sel_ok_reg && occ[p_reg])
                begin
                    wr_en    = 1'b1;
                    wr_slot  = '{rgb: color_reg, total: count_reg, done_cnt: 8'd0,
                                 tmr: 8'd0, period: rd_slot.period};
                    acc_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = acc_reg;
                    out_idx_next   = acc_reg ? 4'(p_reg) : 4'd0;
                    out_lit_next   = lit_reg;
                    out_busy_next  = |occ;
                end
            end
            default: wr_en = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_ptr_reg  <= '0;
            lit_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
            p_reg         <= '0;
            ct_reg        <= '0;
            acc_reg       <= 1'b0;
            req_reg       <= REQ_TICK;
        end
        else
        begin
            state_reg     <= state_next;
            scan_ptr_reg  <= scan_ptr_next;
            lit_reg       <= lit_next;
            out_valid_reg <= out_valid_next;
            p_reg         <= p_next;
            ct_reg        <= ct_next;
            acc_reg       <= acc_next;
            req_reg       <= req_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_next;
        sel_ok_reg   <= sel_ok_next;
        color_reg    <= color_next;
        count_reg    <= count_next;
        wk_reg       <= wk_next;
        out_acc_reg  <= out_acc_next;
        out_idx_reg  <= out_idx_next;
        out_lit_reg  <= out_lit_next;
        out_busy_reg <= out_busy_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.accepted   = out_acc_reg;
    assign out_ch.slot_index = out_idx_reg;
    assign out_ch.led_red    = out_lit_reg[0];
    assign out_ch.led_green  = out_lit_reg[1];
    assign out_ch.led_blue   = out_lit_reg[2];
    assign out_ch.busy_res   = out_busy_reg;

    // A result only appears out of the completion state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
    else $error("result raised outside completion state");

    // An accepted request always names a slot that exists
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_acc_reg) |-> ({1'b0, out_idx_reg} < 5'(SLOTS)))
    else $error("accepted request with slot index out of range");

    // A placed blink request leaves its slot occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && acc_reg && req_reg == REQ_BLINK) |-> occ[p_reg])
    else $error("blink request accepted but slot left free");

    // The scan never looks at more slots than the table holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ({1'b0, ct_reg} < (IDX_W + 1)'(SLOTS)))
    else $error("slot scan ran past the table");

endmodule

@@ hdl/lbcs_alu.sv @@
// ============================================================================
// lbcs_alu
// Shared 8-bit compare and increment unit used by the tick update steps.
// ============================================================================
module lbcs_alu
    import lbcs_pkg::*;
(
    input  alu_op_t    op,
    input  logic [7:0] a,
    input  logic [7:0] b,
    output logic       flag,
    output logic [7:0] inc
);

    // Compare result selected by operation
    always_comb
    begin
        case (op)
            ALU_EQ:  flag = (a == b);
            ALU_LT:  flag = (a < b);
            default: flag = 1'b0;
        endcase
    end

    // Wrapping increment of operand a
    assign inc = a + 8'd1;

endmodule

@@ hdl/lbcs_slot_table.sv @@
// ============================================================================
// lbcs_slot_table
// Slot register file: one read port, one write port, occupancy flags.
// ============================================================================
module lbcs_slot_table
    import lbcs_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF,
    parameter int unsigned IDX_W = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] rd_idx,
    output slot_t            rd_slot,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  slot_t            wr_slot,
    output logic [SLOTS-1:0] occ
);

    slot_t slot_reg [SLOTS];

    // Table storage, all slots free after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_reg[i] <= '{rgb: 3'd0, total: 8'd0, done_cnt: 8'd0,
                                 tmr: 8'd0, period: OFF_FAST_RST};
            end
        end
        else if (wr_en)
        begin
            slot_reg[wr_idx] <= wr_slot;
        end
    end

    // Read port
    assign rd_slot = slot_reg[rd_idx];

    // A slot is occupied while its blink count is nonzero
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            occ[i] = (slot_reg[i].total != 8'd0);
        end
    end

endmodule

@@ tb/tb_led_blink_code_sequencer.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_led_blink_code_sequencer
// Self-checking bench for the LED blink-code sequencer. A clocked driver
// plays requests from a queue onto the request channel. At every accepted
// request the bench's own model of the slot table computes the status that
// must come back. A clocked monitor compares each returned status, field by
// field, in order. Both sides idle at random. Timing registers are rewritten
// between phases, once the block has drained.
// ============================================================================
module tb_led_blink_code_sequencer;
    import lbcs_pkg::*;

    // Type 3 is not a request; the block must treat it as a no-op
    localparam logic [1:0] REQ_NOP = 2'd3;
    localparam int unsigned PHASE_ITEMS = 90;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] slot_sel;
        logic [2:0] led_color;
        logic [7:0] blink_count;
    } led_req_t;

    typedef struct packed {
        logic       accepted;
        logic [3:0] slot_index;
        logic       led_red;
        logic       led_green;
        logic       led_blue;
        logic       busy_res;
    } led_status_t;

    // Clock, reset and block inputs, all known from time zero
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_idx = CFG_ON_TICKS;
    logic [7:0] cfg_data = 8'd0;
    logic       drv_valid = 1'b0;
    led_req_t   drv_req = '0;
    logic       mon_ready = 1'b0;

    int unsigned cycle = 0;
    int unsigned failures = 0;

    lbcs_in_if  in_if ();
    lbcs_out_if out_if ();

    assign in_if.valid       = drv_valid;
    assign in_if.req_type    = drv_req.req_type;
    assign in_if.slot_sel    = drv_req.slot_sel;
    assign in_if.led_color   = drv_req.led_color;
    assign in_if.blink_count = drv_req.blink_count;
    assign out_if.ready      = mon_ready;

    led_blink_code_sequencer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_if),
        .out_ch   (out_if),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
    end

    // ------------------------------------------------------------------
    // Slot table model
    // ------------------------------------------------------------------
    logic [2:0]  tbl_rgb    [SLOTS_DEF];
    logic [7:0]  tbl_total  [SLOTS_DEF];
    logic [7:0]  tbl_done   [SLOTS_DEF];
    logic [7:0]  tbl_time   [SLOTS_DEF];
    logic [7:0]  tbl_period [SLOTS_DEF];
    int unsigned tbl_scan;
    logic [2:0]  tbl_lit;
    logic [7:0]  t_on, t_fast, t_slow, t_gap;

    function automatic int unsigned wrap_slot(int unsigned p);
        return (p + 1 >= SLOTS_DEF) ? 0 : p + 1;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < SLOTS_DEF; i++)
        begin
            tbl_rgb[i]    = '0;
            tbl_total[i]  = '0;
            tbl_done[i]   = '0;
            tbl_time[i]   = '0;
            tbl_period[i] = OFF_FAST_RST;
        end
        tbl_scan = 0;
        tbl_lit  = '0;
        t_on     = ON_TICKS_RST;
        t_fast   = OFF_FAST_RST;
        t_slow   = OFF_SLOW_RST;
        t_gap    = GAP_TICKS_RST;
    endfunction

    // Advance the table by one request and return the status it produces
    function automatic led_status_t play_request(led_req_t rq);
        led_status_t st;
        int unsigned p;
        int unsigned ct;
        int unsigned fi;
        st = '0;
        case (rq.req_type)
            REQ_TICK:
            begin
                p  = tbl_scan;
                ct = 0;
                while (tbl_total[p] == 0 && ct < SLOTS_DEF)
                begin
                    p = wrap_slot(p);
                    ct++;
                end
                tbl_scan = p;
                if (tbl_total[p] != 0)
                begin
                    if (tbl_done[p] >= tbl_total[p])
                        tbl_done[p] = '0;
                    if (tbl_time[p] == 0)
                        tbl_lit = tbl_rgb[p];
                    tbl_time[p] = tbl_time[p] + 8'd1;
                    if (tbl_time[p] == t_on)
                        tbl_lit = '0;
                    if (tbl_time[p] == tbl_period[p])
                    begin
                        tbl_done[p] = tbl_done[p] + 8'd1;
                        if (tbl_done[p] < tbl_total[p])
                            tbl_time[p] = '0;
                    end
                    if (tbl_time[p] == t_gap)
                    begin
                        tbl_time[p] = '0;
                        tbl_scan    = wrap_slot(p);
                    end
                end
            end
            REQ_BLINK:
            begin
                fi = SLOTS_DEF;
                for (int i = SLOTS_DEF - 1; i >= 0; i--)
                    if (tbl_total[i] == 0)
                        fi = i;
                if (fi < SLOTS_DEF && rq.blink_count != 0 && rq.led_color != 0)
                begin
                    tbl_rgb[fi]    = rq.led_color;
                    tbl_total[fi]  = rq.blink_count;
                    tbl_done[fi]   = '0;
                    tbl_time[fi]   = '0;
                    tbl_period[fi] = (rq.led_color == RGB_RED) ? t_slow : t_fast;
                    st.accepted    = 1'b1;
                    st.slot_index  = fi[3:0];
                end
            end
            REQ_CHANGE:
            begin
                // Period is kept; only a blink request sets it
                if (rq.slot_sel < SLOTS_DEF && tbl_total[rq.slot_sel] != 0)
                begin
                    tbl_rgb[rq.slot_sel]   = rq.led_color;
                    tbl_total[rq.slot_sel] = rq.blink_count;
                    tbl_done[rq.slot_sel]  = '0;
                    tbl_time[rq.slot_sel]  = '0;
                    st.accepted            = 1'b1;
                    st.slot_index          = rq.slot_sel;
                end
            end
            default:
            begin
            end
        endcase
        st.led_red   = tbl_lit[0];
        st.led_green = tbl_lit[1];
        st.led_blue  = tbl_lit[2];
        for (int i = 0; i < SLOTS_DEF; i++)
            if (tbl_total[i] != 0)
                st.busy_res = 1'b1;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Queues shared by the stimulus, driver and monitor
    // ------------------------------------------------------------------
    led_req_t    request_q [$];
    led_status_t status_q [$];
    bit          holding = 1'b0;

    // Random idling, switched off in a recurring window of the cycle counter
    function automatic bit idle_now();
        return (cycle % 5000 >= 800) && ($urandom_range(99) < 26);
    endfunction

    // Request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (drv_valid && in_if.ready)
            begin
                status_q.push_back(play_request(drv_req));
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (request_q.size() != 0 && !idle_now())
                begin
                    drv_req   <= request_q.pop_front();
                    drv_valid <= 1'b1;
                    holding    = 1'b1;
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    // Status monitor
    always @(posedge clk)
    begin
        led_status_t want;
        if (rst_n)
        begin
            if (out_if.valid && mon_ready)
            begin
                if (status_q.size() == 0)
                begin
                    $error("status returned with no request outstanding");
                    failures++;
                end
                else
                begin
                    want = status_q.pop_front();
                    check_field("accepted", want.accepted, out_if.accepted);
                    check_field("slot_index", want.slot_index, out_if.slot_index);
                    check_field("led_red", want.led_red, out_if.led_red);
                    check_field("led_green", want.led_green, out_if.led_green);
                    check_field("led_blue", want.led_blue, out_if.led_blue);
                    check_field("busy_res", want.busy_res, out_if.busy_res);
                end
            end
            mon_ready <= !idle_now();
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_req(logic [1:0] kind, logic [3:0] sel, logic [2:0] color,
                                     logic [7:0] count);
        led_req_t rq;
        rq.req_type    = kind;
        rq.slot_sel    = sel;
        rq.led_color   = color;
        rq.blink_count = count;
        request_q.push_back(rq);
    endfunction

    // Mostly ticks, with blink and change traffic kept short so codes cycle
    function automatic void push_random();
        int unsigned r;
        logic [3:0]  sel;
        logic [2:0]  color;
        logic [7:0]  count;
        r     = $urandom_range(99);
        sel   = 4'($urandom_range(15));
        color = 3'($urandom_range(7));
        count = 8'($urandom_range(255));
        if (r < 62)
        begin
            push_req(REQ_TICK, sel, color, count);
        end
        else if (r < 78)
        begin
            if ($urandom_range(99) < 30)
                color = RGB_RED;
            r = $urandom_range(99);
            if (r < 10)
                count = 8'd0;
            else if (r < 85)
                count = 8'($urandom_range(4, 1));
            push_req(REQ_BLINK, sel, color, count);
        end
        else if (r < 93)
        begin
            if ($urandom_range(99) < 85)
                sel = 4'($urandom_range(SLOTS_DEF - 1));
            r = $urandom_range(99);
            if (r < 40)
                count = 8'd0;
            else if (r < 90)
                count = 8'($urandom_range(4, 1));
            push_req(REQ_CHANGE, sel, color, count);
        end
        else
        begin
            push_req(REQ_NOP, sel, color, count);
        end
    endfunction

    task automatic wait_drained();
        @(posedge clk);
        while (request_q.size() != 0 || holding || status_q.size() != 0)
            @(posedge clk);
    endtask

    // Write all four timing registers, one per clock
    task automatic set_timing(input logic [7:0] on_v, input logic [7:0] fast_v,
                              input logic [7:0] slow_v, input logic [7:0] gap_v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ON_TICKS;
        cfg_data <= on_v;
        @(posedge clk);
        t_on      = on_v;
        cfg_idx  <= CFG_OFF_FAST;
        cfg_data <= fast_v;
        @(posedge clk);
        t_fast    = fast_v;
        cfg_idx  <= CFG_OFF_SLOW;
        cfg_data <= slow_v;
        @(posedge clk);
        t_slow    = slow_v;
        cfg_idx  <= CFG_GAP_TICKS;
        cfg_data <= gap_v;
        @(posedge clk);
        t_gap     = gap_v;
        cfg_we   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] plan [7][4];
        plan = '{'{8'd1,   8'd1,   8'd1,   8'd1},
                 '{8'd255, 8'd255, 8'd255, 8'd255},
                 '{8'd2,   8'd6,   8'd9,   8'd25},
                 '{8'd3,   8'd4,   8'd7,   8'd40},
                 '{8'd1,   8'd2,   8'd3,   8'd12},
                 '{8'd2,   8'd5,   8'd8,   8'd255},
                 '{8'd4,   8'd3,   8'd6,   8'd5}};
        clear_table();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, rejects, fill to full, changes, frees
        push_req(REQ_TICK, 4'd0, 3'd0, 8'd0);
        push_req(REQ_BLINK, 4'd0, 3'd5, 8'd0);
        push_req(REQ_BLINK, 4'd0, 3'd0, 8'd3);
        push_req(REQ_CHANGE, 4'd4, 3'd3, 8'd2);
        push_req(REQ_CHANGE, 4'd15, 3'd7, 8'd255);
        push_req(REQ_NOP, 4'd15, 3'd7, 8'd255);
        push_req(REQ_BLINK, 4'd0, RGB_RED, 8'd2);
        push_req(REQ_BLINK, 4'd0, 3'd7, 8'd255);
        for (int i = 2; i < SLOTS_DEF; i++)
            push_req(REQ_BLINK, 4'd0, 3'(i % 7 + 1), 8'd1);
        push_req(REQ_BLINK, 4'd0, 3'd2, 8'd1);
        push_req(REQ_CHANGE, 4'd3, 3'd0, 8'd2);
        push_req(REQ_CHANGE, 4'(SLOTS_DEF - 1), 3'd4, 8'd0);
        repeat (6) push_req(REQ_TICK, 4'd0, 3'd0, 8'd0);
        push_req(REQ_BLINK, 4'd0, 3'd4, 8'd2);
        wait_drained();

        // Random phases over fixed timing sets, extremes first, then random sets
        for (int ph = 0; ph < 7; ph++)
        begin
            set_timing(plan[ph][0], plan[ph][1], plan[ph][2], plan[ph][3]);
            repeat (PHASE_ITEMS) push_random();
            wait_drained();
        end
        for (int ph = 0; ph < 2; ph++)
        begin
            set_timing(8'($urandom_range(8, 1)), 8'($urandom_range(12, 2)),
                       8'($urandom_range(16, 2)), 8'($urandom_range(60, 5)));
            repeat (PHASE_ITEMS) push_random();
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (failures == 0)
            $display("tb_led_blink_code_sequencer: PASS");
        else
            $display("tb_led_blink_code_sequencer: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("tb_led_blink_code_sequencer: FAIL");
        $finish;
    end

endmodule
